/* sv/idc_pkg.sv */
package idc_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned CountW  = 22;
  localparam int unsigned SerialW = 23;
  localparam int unsigned Q100W   = 8;
  localparam int unsigned R100W   = 7;
  localparam int unsigned CumW    = 9;

  // floor(y / 100) == (y * Recip100) >> Recip100Sh for every 14-bit y
  localparam int unsigned Recip100   = 5243;
  localparam int unsigned Recip100Sh = 19;
  localparam int unsigned RecipW     = 13;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic [SerialW-1:0] serial;
    logic               ok;
  } idc_date_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [CumW-1:0] month_base(input logic [MonthW-1:0] m);
    logic [CumW-1:0] base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

/* sv/idc_serial.sv */
module idc_serial
  import idc_pkg::*;
(
  input  logic              clk,
  input  logic [DayW-1:0]   day,
  input  logic [MonthW-1:0] month,
  input  logic [YearW-1:0]  year,
  output idc_date_t         date
);

  localparam int unsigned ProdW = YearW + RecipW;

  // stage a: quotient by 100
  logic [DayW-1:0]   day_a_r;
  logic [MonthW-1:0] month_a_r;
  logic [YearW-1:0]  year_a_r;
  logic [Q100W-1:0]  q100_a_r;
  logic [ProdW-1:0]  prod_nxt;

  assign prod_nxt = ProdW'(year) * ProdW'(Recip100);

  always_ff @(posedge clk) begin
    day_a_r   <= day;
    month_a_r <= month;
    year_a_r  <= year;
    q100_a_r  <= prod_nxt[Recip100Sh +: Q100W];
  end

  // stage b: leap year, validity, ceiling terms
  logic [R100W-1:0]  r100_nxt;
  logic [YearW-1:0]  q100x100;
  logic              leap_nxt;
  logic [DayW-1:0]   dim_nxt;
  logic              ok_nxt;
  logic [CumW-1:0]   cum_nxt;
  logic [YearW-2:0]  c4_nxt;
  logic [Q100W-1:0]  c100_nxt;
  logic [Q100W-2:0]  c400_nxt;

  logic [DayW-1:0]   day_b_r;
  logic [YearW-1:0]  year_b_r;
  logic              ok_b_r;
  logic [CumW-1:0]   cum_b_r;
  logic [YearW-2:0]  c4_b_r;
  logic [Q100W-1:0]  c100_b_r;
  logic [Q100W-2:0]  c400_b_r;

  always_comb begin
    q100x100 = YearW'(q100_a_r) * YearW'(100);
    r100_nxt = R100W'(year_a_r - q100x100);
    leap_nxt = ((year_a_r[1:0] == 2'd0) && (r100_nxt != '0)) ||
               ((r100_nxt == '0) && (q100_a_r[1:0] == 2'd0));
    dim_nxt  = month_len(month_a_r);
    if ((month_a_r == MonthFeb) && leap_nxt) begin
      dim_nxt = dim_nxt + 5'd1;
    end
    ok_nxt   = (month_a_r >= MonthJan) && (month_a_r <= MonthDec) &&
               (day_a_r != '0) && (day_a_r <= dim_nxt);
    cum_nxt  = month_base(month_a_r);
    if ((month_a_r > MonthFeb) && leap_nxt) begin
      cum_nxt = cum_nxt + 9'd1;
    end
    c4_nxt   = year_a_r[YearW-1:2] + (YearW-1)'(year_a_r[1:0] != 2'd0);
    c100_nxt = q100_a_r + Q100W'(r100_nxt != '0);
    c400_nxt = q100_a_r[Q100W-1:2] +
               (Q100W-1)'((r100_nxt != '0) || (q100_a_r[1:0] != 2'd0));
  end

  always_ff @(posedge clk) begin
    day_b_r  <= day_a_r;
    year_b_r <= year_a_r;
    ok_b_r   <= ok_nxt;
    cum_b_r  <= cum_nxt;
    c4_b_r   <= c4_nxt;
    c100_b_r <= c100_nxt;
    c400_b_r <= c400_nxt;
  end

  // stage c: serial day number
  logic [SerialW-1:0] serial_nxt;
  logic [SerialW-1:0] serial_c_r;
  logic               ok_c_r;

  assign serial_nxt = SerialW'(year_b_r) * SerialW'(365)
                    + SerialW'(c4_b_r) - SerialW'(c100_b_r) + SerialW'(c400_b_r)
                    + SerialW'(cum_b_r) + SerialW'(day_b_r);

  always_ff @(posedge clk) begin
    serial_c_r <= serial_nxt;
    ok_c_r     <= ok_b_r;
  end

  assign date.serial = serial_c_r;
  assign date.ok     = ok_c_r;

endmodule

/* sv/inclusive_date_day_count_top.sv */
// channel  ports                                        handshake
// in       in_first_*/in_second_* (day, month, year)   start && !busy
// out      out_day_count, out_dates_valid              out_valid, one cycle
//
// an item enters every cycle; busy stays low
// the result strobe follows start through three stages per date
// (divide by 100, leap and month offset, serial sum) and one for the difference
// synchronous active-low reset clears the valid bits only
// the receiver cannot stall, so the pipeline never holds
module inclusive_date_day_count_top
  import idc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DayW-1:0]   in_first_day,
  input  logic [MonthW-1:0] in_first_month,
  input  logic [YearW-1:0]  in_first_year,
  input  logic [DayW-1:0]   in_second_day,
  input  logic [MonthW-1:0] in_second_month,
  input  logic [YearW-1:0]  in_second_year,
  output logic              out_valid,
  output logic [CountW-1:0] out_day_count,
  output logic              out_dates_valid
);

  idc_date_t date1;
  idc_date_t date2;
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  idc_serial u_serial1 (
    .clk   (clk),
    .day   (in_first_day),
    .month (in_first_month),
    .year  (in_first_year),
    .date  (date1)
  );

  idc_serial u_serial2 (
    .clk   (clk),
    .day   (in_second_day),
    .month (in_second_month),
    .year  (in_second_year),
    .date  (date2)
  );

  logic [2:0] vld_r;
  logic       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[1:0], accept};
      out_valid_r <= vld_r[2];
    end
  end

  // stage d: inclusive difference with saturation
  logic [SerialW-1:0] diff;
  logic [SerialW:0]   cnt;
  logic [CountW-1:0]  count_nxt;
  logic               ok_nxt;
  logic [CountW-1:0]  count_r;
  logic               ok_r;

  always_comb begin
    if (date1.serial >= date2.serial) begin
      diff = date1.serial - date2.serial;
    end else begin
      diff = date2.serial - date1.serial;
    end
    cnt    = {1'b0, diff} + (SerialW+1)'(1);
    ok_nxt = date1.ok && date2.ok;
    if (!ok_nxt) begin
      count_nxt = '0;
    end else if (cnt > (SerialW+1)'(CountMax)) begin
      count_nxt = CountMax;
    end else begin
      count_nxt = cnt[CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    ok_r    <= ok_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_day_count   = count_r;
  assign out_dates_valid = ok_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("item did not reach the output after four cycles");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4))
    else $error("result strobe without a matching item");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dates_valid |-> out_day_count == '0)
    else $error("invalid dates gave a nonzero count");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dates_valid |-> out_day_count != '0)
    else $error("valid dates gave a zero count");

endmodule
